/* rtl/utc_pkg.sv */
// shared constants, stage indices and types for the unix time to calendar converter
package utc_pkg;

    localparam int NUM_STAGES = 10;

    localparam int ST_RECIP = 0;
    localparam int ST_SPLIT = 1;
    localparam int ST_SHIFT = 2;
    localparam int ST_CENT  = 3;
    localparam int ST_NORM  = 4;
    localparam int ST_YOE   = 5;
    localparam int ST_YMUL  = 6;
    localparam int ST_DOY   = 7;
    localparam int ST_MON   = 8;
    localparam int ST_OUT   = 9;

    localparam int TOD_DELAY = ST_OUT - ST_YOE;

    typedef logic [NUM_STAGES-1:0] utc_en_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } utc_tod_t;

    // floor(2^25 / 675), quotient may come out one low
    localparam logic [15:0] DAY_RECIP    = 16'd49710;
    localparam logic [9:0]  DAY_DIV7     = 10'd675;
    localparam logic [12:0] HOUR_RECIP   = 13'd4661;
    localparam logic [11:0] SECS_HOUR    = 12'd3600;
    localparam logic [10:0] MIN_RECIP    = 11'd1093;
    localparam logic [5:0]  SECS_MIN     = 6'd60;
    localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
    localparam logic [19:0] ERA5_BASE    = 20'd730485;
    localparam logic [19:0] ERA4_BASE    = 20'd584388;
    localparam logic [17:0] LAST_DOE     = 18'd146096;
    localparam logic [17:0] CENT1        = 18'd36524;
    localparam logic [17:0] CENT2        = 18'd73048;
    localparam logic [17:0] CENT3        = 18'd109572;
    localparam logic [15:0] YEAR_RECIP   = 16'd45965;
    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [5:0]  CENT_RECIP   = 6'd41;
    localparam logic [10:0] MON_RECIP    = 11'd1714;
    localparam logic [8:0]  ERA_YEARS    = 9'd400;

    // first day of each march-based month within the shifted year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/utc_days.sv */
// split of the timestamp into whole days and seconds of the day
module utc_days (
    input  logic              clk,
    input  utc_pkg::utc_en_t  en,
    input  logic [31:0]       unix_seconds,
    output logic [15:0]       days,
    output logic [16:0]       sod
);

    logic [24:0] x_reg, x_next;
    logic [6:0]  lo_reg, lo_next;
    logic [15:0] q0_reg, q0_next;
    logic [40:0] prod;
    logic [15:0] days_reg, days_next;
    logic [16:0] sod_reg, sod_next;
    logic [25:0] qm;
    logic [24:0] rem;
    logic        fix;
    logic [10:0] r;

    assign x_next  = unix_seconds[31:7];
    assign lo_next = unix_seconds[6:0];
    assign prod    = {16'd0, x_next} * {25'd0, utc_pkg::DAY_RECIP};
    assign q0_next = prod[40:25];

    assign qm        = {10'd0, q0_reg} * {16'd0, utc_pkg::DAY_DIV7};
    assign rem       = x_reg - qm[24:0];
    assign fix       = rem[10:0] >= {1'b0, utc_pkg::DAY_DIV7};
    assign r         = fix ? rem[10:0] - {1'b0, utc_pkg::DAY_DIV7} : rem[10:0];
    assign days_next = fix ? q0_reg + 16'd1 : q0_reg;
    assign sod_next  = {r[9:0], lo_reg};

    always_ff @(posedge clk)
    begin
        if (en[utc_pkg::ST_RECIP])
        begin
            x_reg  <= x_next;
            lo_reg <= lo_next;
            q0_reg <= q0_next;
        end
        if (en[utc_pkg::ST_SPLIT])
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

/* rtl/utc_tod.sv */
// hours, minutes and seconds from the seconds of the day, then aligned to the date path
module utc_tod (
    input  logic              clk,
    input  utc_pkg::utc_en_t  en,
    input  logic [16:0]       sod,
    output utc_pkg::utc_tod_t tod
);

    logic [16:0] sod_reg, sod_next;
    logic [4:0]  hours_reg, hours_next;
    logic [4:0]  hours3_reg, hours4_reg, hours5_reg;
    logic [25:0] hprod;
    logic [16:0] hsec;
    logic [11:0] remh_reg, remh_next;
    logic [11:0] remh4_reg;
    logic [20:0] mprod;
    logic [5:0]  mins_reg, mins_next;
    logic [5:0]  mins5_reg;
    logic [11:0] msec;
    logic [11:0] sdiff;
    logic [5:0]  secs_reg, secs_next;
    utc_pkg::utc_tod_t dly_reg [utc_pkg::TOD_DELAY];

    assign sod_next   = sod;
    assign hprod      = {13'd0, sod[16:4]} * {13'd0, utc_pkg::HOUR_RECIP};
    assign hours_next = hprod[24:20];

    assign hsec      = {12'd0, hours_reg} * {5'd0, utc_pkg::SECS_HOUR};
    assign remh_next = 12'(sod_reg - hsec);

    assign mprod     = {11'd0, remh_reg[11:2]} * {10'd0, utc_pkg::MIN_RECIP};
    assign mins_next = mprod[19:14];

    assign msec      = {6'd0, mins_reg} * {6'd0, utc_pkg::SECS_MIN};
    assign sdiff     = remh4_reg - msec;
    assign secs_next = sdiff[5:0];

    always_ff @(posedge clk)
    begin
        if (en[utc_pkg::ST_SHIFT])
        begin
            sod_reg   <= sod_next;
            hours_reg <= hours_next;
        end
        if (en[utc_pkg::ST_CENT])
        begin
            remh_reg   <= remh_next;
            hours3_reg <= hours_reg;
        end
        if (en[utc_pkg::ST_NORM])
        begin
            mins_reg   <= mins_next;
            remh4_reg  <= remh_reg;
            hours4_reg <= hours3_reg;
        end
        if (en[utc_pkg::ST_YOE])
        begin
            secs_reg   <= secs_next;
            mins5_reg  <= mins_reg;
            hours5_reg <= hours4_reg;
        end
        if (en[utc_pkg::ST_YMUL])
        begin
            dly_reg[0] <= '{hours: hours5_reg, minutes: mins5_reg, seconds: secs_reg};
        end
        for (int i = 1; i < utc_pkg::TOD_DELAY; i++)
        begin
            if (en[utc_pkg::ST_YMUL + i])
            begin
                dly_reg[i] <= dly_reg[i - 1];
            end
        end
    end

    assign tod = dly_reg[utc_pkg::TOD_DELAY - 1];

endmodule

/* rtl/utc_date.sv */
// civil date from the day count, one step of the era arithmetic per stage
module utc_date (
    input  logic              clk,
    input  utc_pkg::utc_en_t  en,
    input  logic [15:0]       days,
    output logic [11:0]       year,
    output logic [3:0]        month,
    output logic [4:0]        day_of_month
);

    // era split
    logic [19:0] shifted;
    logic        era5;
    logic [19:0] doe_full;
    logic [17:0] doe2_reg, doe2_next;
    logic [2:0]  cyc2_reg, cyc2_next;

    // corrections for the four-year, century and era leap days
    logic [31:0] aprod;
    logic [6:0]  a_reg, a_next;
    logic [2:0]  b_reg, b_next;
    logic        c_reg, c_next;
    logic [17:0] doe3_reg;
    logic [2:0]  cyc3_reg;

    logic [17:0] n_reg, n_next;
    logic [17:0] doe4_reg;
    logic [2:0]  cyc4_reg;

    logic [33:0] yprod;
    logic [8:0]  yoe_reg, yoe_next;
    logic [17:0] doe5_reg;
    logic [2:0]  cyc5_reg;

    logic [17:0] m365_reg, m365_next;
    logic [12:0] cprod;
    logic [1:0]  c100_reg, c100_next;
    logic [8:0]  yoe6_reg;
    logic [17:0] doe6_reg;
    logic [2:0]  cyc6_reg;

    logic [17:0] ysub;
    logic [17:0] ddiff;
    logic [8:0]  doy_reg, doy_next;
    logic [8:0]  yoe7_reg;
    logic [2:0]  cyc7_reg;

    logic [10:0] v;
    logic [21:0] mpprod;
    logic [3:0]  mp_reg, mp_next;
    logic [8:0]  doy8_reg;
    logic [8:0]  yoe8_reg;
    logic [2:0]  cyc8_reg;

    logic [8:0]  dom_full;
    logic [11:0] era_years;
    logic        jan_feb;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  dom_reg, dom_next;

    assign shifted   = {4'd0, days} + utc_pkg::EPOCH_SHIFT;
    assign era5      = shifted >= utc_pkg::ERA5_BASE;
    assign cyc2_next = era5 ? 3'd5 : 3'd4;
    assign doe_full  = shifted - (era5 ? utc_pkg::ERA5_BASE : utc_pkg::ERA4_BASE);
    assign doe2_next = doe_full[17:0];

    assign aprod  = {16'd0, doe2_reg[17:2]} * {16'd0, utc_pkg::YEAR_RECIP};
    assign a_next = aprod[30:24];
    assign c_next = doe2_reg == utc_pkg::LAST_DOE;

    always_comb
    begin
        priority if (doe2_reg >= utc_pkg::LAST_DOE)
            b_next = 3'd4;
        else if (doe2_reg >= utc_pkg::CENT3)
            b_next = 3'd3;
        else if (doe2_reg >= utc_pkg::CENT2)
            b_next = 3'd2;
        else if (doe2_reg >= utc_pkg::CENT1)
            b_next = 3'd1;
        else
            b_next = 3'd0;
    end

    assign n_next = doe3_reg - {11'd0, a_reg} + {15'd0, b_reg} - {17'd0, c_reg};

    assign yprod    = {16'd0, n_reg} * {18'd0, utc_pkg::YEAR_RECIP};
    assign yoe_next = yprod[32:24];

    assign m365_next = {9'd0, yoe_reg} * {9'd0, utc_pkg::DAYS_YEAR};
    assign cprod     = {6'd0, yoe_reg[8:2]} * {7'd0, utc_pkg::CENT_RECIP};
    assign c100_next = cprod[11:10];

    assign ysub     = m365_reg + {11'd0, yoe6_reg[8:2]} - {16'd0, c100_reg};
    assign ddiff    = doe6_reg - ysub;
    assign doy_next = ddiff[8:0];

    assign v       = {doy_reg, 2'b00} + {2'd0, doy_reg} + 11'd2;
    assign mpprod  = {11'd0, v} * {11'd0, utc_pkg::MON_RECIP};
    assign mp_next = mpprod[21:18];

    assign dom_full   = doy8_reg - utc_pkg::month_start(mp_reg) + 9'd1;
    assign dom_next   = dom_full[4:0];
    assign jan_feb    = mp_reg >= 4'd10;
    assign month_next = jan_feb ? mp_reg - 4'd9 : mp_reg + 4'd3;
    assign era_years  = {9'd0, cyc8_reg} * {3'd0, utc_pkg::ERA_YEARS};
    assign year_next  = era_years + {3'd0, yoe8_reg} + {11'd0, jan_feb};

    always_ff @(posedge clk)
    begin
        if (en[utc_pkg::ST_SHIFT])
        begin
            doe2_reg <= doe2_next;
            cyc2_reg <= cyc2_next;
        end
        if (en[utc_pkg::ST_CENT])
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            doe3_reg <= doe2_reg;
            cyc3_reg <= cyc2_reg;
        end
        if (en[utc_pkg::ST_NORM])
        begin
            n_reg    <= n_next;
            doe4_reg <= doe3_reg;
            cyc4_reg <= cyc3_reg;
        end
        if (en[utc_pkg::ST_YOE])
        begin
            yoe_reg  <= yoe_next;
            doe5_reg <= doe4_reg;
            cyc5_reg <= cyc4_reg;
        end
        if (en[utc_pkg::ST_YMUL])
        begin
            m365_reg <= m365_next;
            c100_reg <= c100_next;
            yoe6_reg <= yoe_reg;
            doe6_reg <= doe5_reg;
            cyc6_reg <= cyc5_reg;
        end
        if (en[utc_pkg::ST_DOY])
        begin
            doy_reg  <= doy_next;
            yoe7_reg <= yoe6_reg;
            cyc7_reg <= cyc6_reg;
        end
        if (en[utc_pkg::ST_MON])
        begin
            mp_reg   <= mp_next;
            doy8_reg <= doy_reg;
            yoe8_reg <= yoe7_reg;
            cyc8_reg <= cyc7_reg;
        end
        if (en[utc_pkg::ST_OUT])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

endmodule

/* rtl/unix_time_to_calendar.sv */
// top level: unix timestamp to utc date and time of day
// throughput: one item per cycle while cal_ready is high; ten pipeline stages, each with its own valid bit
// a stage takes new data whenever it is empty or its successor moves, so bubbles close up
// rst_n clears the valid bits only; datapath registers are not reset
module unix_time_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ts_valid,
    output logic        ts_ready,
    input  logic [31:0] unix_seconds,
    output logic        cal_valid,
    input  logic        cal_ready,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds_of_minute
);

    localparam int N = utc_pkg::NUM_STAGES;

    logic [N-1:0]      valid_reg, valid_next;
    utc_pkg::utc_en_t  en;
    logic [15:0]       days;
    logic [16:0]       sod;
    utc_pkg::utc_tod_t tod;

    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || cal_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 0) ? ts_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    utc_days u_days (
        .clk          (clk),
        .en           (en),
        .unix_seconds (unix_seconds),
        .days         (days),
        .sod          (sod)
    );

    utc_tod u_tod (
        .clk (clk),
        .en  (en),
        .sod (sod),
        .tod (tod)
    );

    utc_date u_date (
        .clk          (clk),
        .en           (en),
        .days         (days),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    assign ts_ready          = en[0];
    assign cal_valid         = valid_reg[N-1];
    assign hours             = tod.hours;
    assign minutes           = tod.minutes;
    assign seconds_of_minute = tod.seconds;

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
                       && month <= 4'd12 && day_of_month >= 5'd1 && day_of_month <= 5'd31))
        else $error("date out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (hours <= 5'd23 && minutes <= 6'd59 && seconds_of_minute <= 6'd59))
        else $error("time of day out of range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ts_ready |-> (&valid_reg && !cal_ready))
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_valid && cal_ready && !valid_reg[N-2]) |=> !cal_valid)
        else $error("result item repeated");

endmodule
